// ----- hw/rtl/cgbq_pkg.sv -----
package cgbq_pkg;

    localparam int X_W       = 16;
    localparam int ID_W      = 16;
    localparam int CW_W      = 12;
    localparam int WIN_W     = 3;
    localparam int CNT_W     = 4;
    localparam int COL_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int ACT_W     = 2;
    localparam int ST_W      = 2;

    localparam logic [CW_W-1:0]  CELL_WIDTH_RST = 12'd144;
    localparam logic [WIN_W-1:0] WINDOW_RST     = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_WIDTH   = 1'b0,
        CFG_WINDOW_CELLS = 1'b1
    } cfg_idx_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        EMIT_NONE   = 3'd0,
        EMIT_OK     = 3'd1,
        EMIT_RANGE  = 3'd2,
        EMIT_INSERT = 3'd3,
        EMIT_QUERY  = 3'd4
    } emit_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INS,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_ALL_RD,
        S_ALL_WR,
        S_DIV_QRY,
        S_Q_COL,
        S_Q_CNT,
        S_Q_ENT,
        S_Q_END
    } state_t;

    typedef struct packed {
        logic  load_ins;
        logic  load_qry;
        logic  clear_grid;
        logic  col_from_div;
        logic  col_zero;
        logic  col_step;
        logic  cnt_rd;
        logic  ent_wr;
        logic  cnt_latch;
        logic  ent_rd;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic col_neg;
        logic col_over;
        logic col_in_range;
        logic col_is_last;
        logic win_done;
        logic cnt_zero;
        logic h_last;
    } sts_t;

endpackage

// ----- hw/rtl/cgbq_ram.sv -----
module cgbq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/cgbq_div.sv -----
module cgbq_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [cgbq_pkg::X_W-1:0]     dividend,
    input  logic [cgbq_pkg::CW_W-1:0]           divisor,
    output logic                                done,
    output logic signed [cgbq_pkg::COL_W-1:0]   quotient
);

    localparam int X_W    = cgbq_pkg::X_W;
    localparam int CW_W   = cgbq_pkg::CW_W;
    localparam int COL_W  = cgbq_pkg::COL_W;
    localparam int STEP_W = $clog2(X_W + 1);

    logic              run_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [X_W-1:0]    num_reg;
    logic [CW_W-1:0]   rem_reg;
    logic [CW_W-1:0]   den_reg;

    logic [X_W-1:0]    mag_in;
    logic [CW_W:0]     shifted;
    logic [CW_W:0]     diff;
    logic              ge;
    logic [COL_W-1:0]  mag_out;

    assign mag_in  = dividend[X_W-1] ? X_W'(-dividend) : X_W'(dividend);
    assign shifted = {rem_reg, num_reg[X_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign mag_out = {1'b0, num_reg};

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            step_reg <= STEP_W'(X_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= dividend[X_W-1];
            num_reg <= mag_in;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? CW_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[X_W-2:0], ge};
            rem_reg <= ge ? diff[CW_W-1:0] : shifted[CW_W-1:0];
        end
    end

    assign done     = !run_reg;
    assign quotient = neg_reg ? $signed(-mag_out) : $signed(mag_out);

endmodule

// ----- hw/rtl/cgbq_datapath.sv -----
module cgbq_datapath #(
    parameter int NUM_COLUMNS  = 40,
    parameter int COLUMN_DEPTH = 8,
    parameter int MAX_WINDOW   = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cgbq_pkg::cmd_t                       cmd,
    output cgbq_pkg::sts_t                       sts,
    input  logic signed [cgbq_pkg::X_W-1:0]      object_x,
    input  logic [cgbq_pkg::ID_W-1:0]            object_id,
    input  logic signed [cgbq_pkg::X_W-1:0]      camera_x,
    input  logic                                 cfg_valid,
    input  logic [cgbq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cgbq_pkg::CW_W-1:0]            cfg_data,
    output logic                                 strobe,
    output logic [cgbq_pkg::ID_W-1:0]            found_id,
    output logic                                 found_valid,
    output logic [cgbq_pkg::ST_W-1:0]            status,
    output logic                                 last
);

    localparam int X_W       = cgbq_pkg::X_W;
    localparam int ID_W      = cgbq_pkg::ID_W;
    localparam int CW_W      = cgbq_pkg::CW_W;
    localparam int WIN_W     = cgbq_pkg::WIN_W;
    localparam int CNT_W     = cgbq_pkg::CNT_W;
    localparam int COL_W     = cgbq_pkg::COL_W;
    localparam int CIDX_W    = $clog2(NUM_COLUMNS);
    localparam int ENT_DEPTH = NUM_COLUMNS * COLUMN_DEPTH;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int WCNT_W    = $clog2(MAX_WINDOW + 1);

    localparam logic signed [COL_W-1:0] N_COL    = COL_W'(NUM_COLUMNS);
    localparam logic signed [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);
    localparam logic [CNT_W-1:0]        DEPTH_C  = CNT_W'(COLUMN_DEPTH);
    localparam logic [WIN_W:0]          MAXW_C   = (WIN_W + 1)'(MAX_WINDOW);

    logic [CW_W-1:0]          cell_width_reg;
    logic [WIN_W-1:0]         window_cells_reg;
    logic [ID_W-1:0]          id_reg;
    logic signed [COL_W-1:0]  col_reg;
    logic [WCNT_W-1:0]        w_reg;
    logic [NUM_COLUMNS-1:0]   valid_reg;
    logic                     cnt_vld_reg;
    logic                     full_reg;
    logic [CNT_W-1:0]         lim_reg;
    logic [CNT_W-1:0]         h_reg;
    logic                     ent_pend_reg;
    logic                     pend_valid_reg;
    logic [ID_W-1:0]          pend_id_reg;

    logic                     strobe_reg;
    logic                     strobe_next;
    logic [ID_W-1:0]          found_id_reg;
    logic [ID_W-1:0]          found_id_next;
    logic                     found_valid_reg;
    logic                     found_valid_next;
    cgbq_pkg::status_t        status_reg;
    cgbq_pkg::status_t        status_next;
    logic                     last_reg;
    logic                     last_next;

    logic                     div_go;
    logic signed [X_W-1:0]    div_operand;
    logic                     div_done;
    logic signed [COL_W-1:0]  div_quotient;

    logic [CIDX_W-1:0]        col_idx;
    logic [WCNT_W-1:0]        win_eff;
    logic [CNT_W-1:0]         cnt_rdata;
    logic [CNT_W-1:0]         cnt_eff;
    logic [CNT_W-1:0]         cnt_cl;
    logic                     can_push;
    logic                     push;
    logic [ENT_AW-1:0]        ent_base;
    logic [ENT_AW-1:0]        ent_wr_addr;
    logic [ENT_AW-1:0]        ent_rd_addr;
    logic [ID_W-1:0]          ent_rdata;
    logic                     insert_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg   <= cgbq_pkg::CELL_WIDTH_RST;
            window_cells_reg <= cgbq_pkg::WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cgbq_pkg::CFG_CELL_WIDTH:   cell_width_reg   <= cfg_data;
                cgbq_pkg::CFG_WINDOW_CELLS: window_cells_reg <= cfg_data[WIN_W-1:0];
                default:                    ;
            endcase
        end
    end

    // column divide
    assign div_go      = cmd.load_ins | cmd.load_qry;
    assign div_operand = cmd.load_ins ? object_x : camera_x;

    cgbq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_operand),
        .divisor  (cell_width_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign col_idx = col_reg[CIDX_W-1:0];
    assign win_eff = ({1'b0, window_cells_reg} > MAXW_C) ? WCNT_W'(MAX_WINDOW)
                                                         : WCNT_W'(window_cells_reg);

    // column counts: ram plus a valid bit per column
    cgbq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_COLUMNS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (col_idx),
        .wr_data (cnt_eff + 1'b1),
        .rd_en   (cmd.cnt_rd),
        .rd_addr (col_idx),
        .rd_data (cnt_rdata)
    );

    assign cnt_eff  = cnt_vld_reg ? cnt_rdata : '0;
    assign cnt_cl   = (cnt_eff > DEPTH_C) ? DEPTH_C : cnt_eff;
    assign can_push = (cnt_eff < DEPTH_C);
    assign push     = cmd.ent_wr & can_push;

    assign ent_base    = ENT_AW'(col_idx) * ENT_AW'(COLUMN_DEPTH);
    assign ent_wr_addr = ent_base + ENT_AW'(cnt_eff);
    assign ent_rd_addr = ent_base + ENT_AW'(h_reg);

    cgbq_ram #(
        .WIDTH (ID_W),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (ent_wr_addr),
        .wr_data (id_reg),
        .rd_en   (cmd.ent_rd),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rdata)
    );

    assign insert_full = full_reg | (cmd.ent_wr & !can_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            full_reg       <= 1'b0;
            ent_pend_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg   <= strobe_next;
            ent_pend_reg <= cmd.ent_rd;
            if (cmd.clear_grid)
            begin
                valid_reg <= '0;
            end
            else if (push)
            begin
                valid_reg[col_idx] <= 1'b1;
            end
            if (div_go)
            begin
                full_reg       <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.ent_wr && !can_push)
                begin
                    full_reg <= 1'b1;
                end
                if (ent_pend_reg)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_id_reg    <= found_id_next;
        found_valid_reg <= found_valid_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
        if (cmd.load_ins)
        begin
            id_reg <= object_id;
        end
        if (cmd.cnt_rd)
        begin
            cnt_vld_reg <= valid_reg[col_idx];
        end
        if (cmd.col_from_div)
        begin
            col_reg <= div_quotient;
            w_reg   <= '0;
        end
        else if (cmd.col_zero)
        begin
            col_reg <= '0;
        end
        else if (cmd.col_step)
        begin
            col_reg <= col_reg + 1'b1;
            w_reg   <= w_reg + 1'b1;
        end
        if (cmd.cnt_latch)
        begin
            lim_reg <= cnt_cl;
            h_reg   <= '0;
        end
        else if (cmd.ent_rd)
        begin
            h_reg <= h_reg + 1'b1;
        end
        if (ent_pend_reg)
        begin
            pend_id_reg <= ent_rdata;
        end
    end

    // result register; a listed id is held back one step so the final one can carry last
    always_comb
    begin
        strobe_next      = 1'b0;
        found_id_next    = '0;
        found_valid_next = 1'b0;
        status_next      = cgbq_pkg::ST_OK;
        last_next        = 1'b1;
        case (cmd.emit)
            cgbq_pkg::EMIT_NONE:
            begin
                if (ent_pend_reg && pend_valid_reg)
                begin
                    strobe_next      = 1'b1;
                    found_id_next    = pend_id_reg;
                    found_valid_next = 1'b1;
                    last_next        = 1'b0;
                end
            end
            cgbq_pkg::EMIT_OK:
            begin
                strobe_next = 1'b1;
            end
            cgbq_pkg::EMIT_RANGE:
            begin
                strobe_next = 1'b1;
                status_next = cgbq_pkg::ST_RANGE;
            end
            cgbq_pkg::EMIT_INSERT:
            begin
                strobe_next = 1'b1;
                status_next = insert_full ? cgbq_pkg::ST_FULL : cgbq_pkg::ST_OK;
            end
            cgbq_pkg::EMIT_QUERY:
            begin
                strobe_next      = 1'b1;
                found_id_next    = pend_valid_reg ? pend_id_reg : '0;
                found_valid_next = pend_valid_reg;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    assign strobe      = strobe_reg;
    assign found_id    = found_id_reg;
    assign found_valid = found_valid_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    assign sts.div_done     = div_done;
    assign sts.col_neg      = col_reg[COL_W-1];
    assign sts.col_over     = !col_reg[COL_W-1] && (col_reg >= N_COL);
    assign sts.col_in_range = !col_reg[COL_W-1] && (col_reg < N_COL);
    assign sts.col_is_last  = (col_reg == LAST_COL);
    assign sts.win_done     = (w_reg == win_eff);
    assign sts.cnt_zero     = (cnt_cl == '0);
    assign sts.h_last       = (CNT_W'(h_reg + 1'b1) == lim_reg);

endmodule

// ----- hw/rtl/cgbq_ctrl.sv -----
module cgbq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cgbq_pkg::ACT_W-1:0]    action,
    input  cgbq_pkg::sts_t                sts,
    output cgbq_pkg::cmd_t                cmd,
    output logic                          busy
);

    cgbq_pkg::state_t state_reg;
    cgbq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgbq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            cgbq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        cgbq_pkg::ACT_CLEAR:
                        begin
                            cmd.clear_grid = 1'b1;
                            cmd.emit       = cgbq_pkg::EMIT_OK;
                        end
                        cgbq_pkg::ACT_INSERT:
                        begin
                            cmd.load_ins = 1'b1;
                            state_next   = cgbq_pkg::S_DIV_INS;
                        end
                        cgbq_pkg::ACT_QUERY:
                        begin
                            cmd.load_qry = 1'b1;
                            state_next   = cgbq_pkg::S_DIV_QRY;
                        end
                        default:
                        begin
                            state_next = cgbq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            cgbq_pkg::S_DIV_INS:
            begin
                if (sts.div_done)
                begin
                    cmd.col_from_div = 1'b1;
                    state_next       = cgbq_pkg::S_INS_CHK;
                end
            end
            cgbq_pkg::S_INS_CHK:
            begin
                if (sts.col_neg)
                begin
                    cmd.col_zero = 1'b1;
                    state_next   = cgbq_pkg::S_ALL_RD;
                end
                else if (sts.col_over)
                begin
                    cmd.emit   = cgbq_pkg::EMIT_RANGE;
                    state_next = cgbq_pkg::S_IDLE;
                end
                else
                begin
                    state_next = cgbq_pkg::S_INS_RD;
                end
            end
            cgbq_pkg::S_INS_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = cgbq_pkg::S_INS_WR;
            end
            cgbq_pkg::S_INS_WR:
            begin
                cmd.ent_wr = 1'b1;
                cmd.emit   = cgbq_pkg::EMIT_INSERT;
                state_next = cgbq_pkg::S_IDLE;
            end
            cgbq_pkg::S_ALL_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = cgbq_pkg::S_ALL_WR;
            end
            cgbq_pkg::S_ALL_WR:
            begin
                cmd.ent_wr = 1'b1;
                if (sts.col_is_last)
                begin
                    cmd.emit   = cgbq_pkg::EMIT_INSERT;
                    state_next = cgbq_pkg::S_IDLE;
                end
                else
                begin
                    cmd.col_step = 1'b1;
                    state_next   = cgbq_pkg::S_ALL_RD;
                end
            end
            cgbq_pkg::S_DIV_QRY:
            begin
                if (sts.div_done)
                begin
                    cmd.col_from_div = 1'b1;
                    state_next       = cgbq_pkg::S_Q_COL;
                end
            end
            cgbq_pkg::S_Q_COL:
            begin
                if (sts.win_done)
                begin
                    state_next = cgbq_pkg::S_Q_END;
                end
                else if (sts.col_in_range)
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = cgbq_pkg::S_Q_CNT;
                end
                else
                begin
                    cmd.col_step = 1'b1;
                end
            end
            cgbq_pkg::S_Q_CNT:
            begin
                cmd.cnt_latch = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.col_step = 1'b1;
                    state_next   = cgbq_pkg::S_Q_COL;
                end
                else
                begin
                    state_next = cgbq_pkg::S_Q_ENT;
                end
            end
            cgbq_pkg::S_Q_ENT:
            begin
                cmd.ent_rd = 1'b1;
                if (sts.h_last)
                begin
                    cmd.col_step = 1'b1;
                    state_next   = cgbq_pkg::S_Q_COL;
                end
            end
            cgbq_pkg::S_Q_END:
            begin
                cmd.emit   = cgbq_pkg::EMIT_QUERY;
                state_next = cgbq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cgbq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != cgbq_pkg::S_IDLE);

endmodule

// ----- hw/rtl/column_grid_bucket_query.sv -----
// one-dimensional grid of columns, each a bounded list of object ids
// command channel: a transaction is taken when start is high and busy is low;
// action selects clear, insert or query, action 3 is dropped with no result
// results leave one per cycle on found_id/found_valid/status/last, marked by
// strobe; the receiver cannot stall, every result is taken in its cycle
// config channel: cfg_index 0 is cell_width, 1 is window_cells, written when
// cfg_valid is high (cfg_ready is always high); the user must write them only
// while the block is idle, which the block itself does not enforce
// clear gives a registered result; insert and query first run the bit-serial
// column divider; an insert into one column then reads and writes that column,
// and a negative insert touches every column in turn
// query walks the columns of its window and reads each listed id in turn,
// through the single read port of the count and entry rams
// for insert and query, busy stays high until the final result is issued, then
// a new command may start the next cycle
// reset: cell_width 144, window_cells 5, grid empty; entry storage is not cleared
module column_grid_bucket_query #(
    parameter int NUM_COLUMNS  = 40,
    parameter int COLUMN_DEPTH = 8,
    parameter int MAX_WINDOW   = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [cgbq_pkg::ACT_W-1:0]           action,
    input  logic signed [cgbq_pkg::X_W-1:0]      object_x,
    input  logic [cgbq_pkg::ID_W-1:0]            object_id,
    input  logic signed [cgbq_pkg::X_W-1:0]      camera_x,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cgbq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cgbq_pkg::CW_W-1:0]            cfg_data,
    output logic                                 strobe,
    output logic [cgbq_pkg::ID_W-1:0]            found_id,
    output logic                                 found_valid,
    output logic [cgbq_pkg::ST_W-1:0]            status,
    output logic                                 last
);

    cgbq_pkg::cmd_t cmd;
    cgbq_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    cgbq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    cgbq_datapath #(
        .NUM_COLUMNS  (NUM_COLUMNS),
        .COLUMN_DEPTH (COLUMN_DEPTH),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .object_x    (object_x),
        .object_id   (object_id),
        .camera_x    (camera_x),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .found_id    (found_id),
        .found_valid (found_valid),
        .status      (status),
        .last        (last)
    );

endmodule
